[rtl/core/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; every module of the block imports this package.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
    localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CHAR_W-1:0] NL_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0] CR_CODE     = 8'd13;

    // request codes as seen on the input channel
    localparam logic [REQ_W-1:0] REQ_PUT_CHAR   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUT_AT     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET_CURSOR = 3'd4;

    // configuration port
    localparam int               PADDR_W        = 3;
    localparam logic             REG_TEXT_COLOR = 1'b0;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_RETURN,
        OP_WRITE_AT,
        OP_READ,
        OP_CLEAR,
        OP_SET_CURSOR
    } op_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic [ADDR_W-1:0] cursor_pos;
        logic              scrolled;
    } rsp_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] cell_data;
    } cmd_t;

endpackage

[rtl/core/tcw_front.sv]
// Front end: accepts requests, checks ranges and turns them into commands.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front import tcw_pkg::*;
(
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    input  logic [CHAR_W-1:0] text_color,
    input  logic              init_busy,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    localparam int PROD_W = COL_W + ROW_W;

    logic [PROD_W-1:0] at_lin;

    assign req_stall = q_full || init_busy;
    assign push      = req_valid && !req_stall;

    always_comb
    begin
        at_lin = PROD_W'(req.row) * PROD_W'(COLUMNS) + PROD_W'(req.column);
        push_cmd.op        = OP_NOP;
        push_cmd.addr      = '0;
        push_cmd.cell_data = {text_color, req.char_code};
        case (req.req_type)
            REQ_PUT_CHAR:
            begin
                if (req.char_code == NL_CODE)
                begin
                    push_cmd.op = OP_NEWLINE;
                end
                else if (req.char_code == CR_CODE)
                begin
                    push_cmd.op = OP_RETURN;
                end
                else
                begin
                    push_cmd.op = OP_PUT_CHAR;
                end
            end
            REQ_PUT_AT:
            begin
                // off-grid targets are dropped
                if (int'(req.column) < COLUMNS && int'(req.row) < ROWS)
                begin
                    push_cmd.op   = OP_WRITE_AT;
                    push_cmd.addr = at_lin[ADDR_W-1:0];
                end
            end
            REQ_READ:
            begin
                if (int'(req.position) < CELLS)
                begin
                    push_cmd.op   = OP_READ;
                    push_cmd.addr = req.position;
                end
            end
            REQ_CLEAR:
            begin
                push_cmd.op = OP_CLEAR;
            end
            REQ_SET_CURSOR:
            begin
                push_cmd.op   = OP_SET_CURSOR;
                push_cmd.addr = (int'(req.position) < CELLS) ? req.position
                                                              : ADDR_W'(CELLS - 1);
            end
            default:
            begin
                push_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

[rtl/core/tcw_queue.sv]
// Short command queue decoupling the front end from the screen engine.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t              entries [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/tcw_back.sv]
// Screen engine: cell memory, cursor, scroll/clear sequencer and result register.
// Depends on tcw_pkg; takes commands from tcw_queue.
module tcw_back import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic pop,
    output logic init_busy,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_COPY,
        ST_FILL,
        ST_RESPOND
    } state_t;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    state_t            state_reg,      state_next;
    logic [ADDR_W-1:0] cursor_reg,     cursor_next;
    logic [COL_W-1:0]  col_reg,        col_next;
    logic [ROW_W-1:0]  row_reg,        row_next;
    logic [ADDR_W-1:0] cnt_reg,        cnt_next;
    logic              init_reg,       init_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg,  pend_addr_next;
    logic [CHAR_W-1:0] res_char_reg,   res_char_next;
    logic [CHAR_W-1:0] res_attr_reg,   res_attr_next;
    logic              res_scr_reg,    res_scr_next;
    logic              rsp_valid_reg,  rsp_valid_next;
    rsp_t              rsp_reg,        rsp_next;

    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [ADDR_W-1:0] rd_addr;
    logic              do_scroll;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign init_busy = init_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cnt_next        = cnt_reg;
        init_next       = init_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_char_next   = res_char_reg;
        res_attr_next   = res_attr_reg;
        res_scr_next    = res_scr_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = cursor_reg;
        mem_wd          = q_cmd.cell_data;
        rd_addr         = q_cmd.addr;
        do_scroll       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop           = 1'b1;
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    case (q_cmd.op)
                        OP_PUT_CHAR:
                        begin
                            mem_we      = 1'b1;
                            cursor_next = cursor_reg + 1'b1;
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                col_next = '0;
                                if (row_reg == ROW_W'(ROWS - 1))
                                begin
                                    do_scroll = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next    = '0;
                            cursor_next = cursor_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                do_scroll = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        OP_RETURN:
                        begin
                            col_next    = '0;
                            cursor_next = cursor_reg - ADDR_W'(col_reg);
                        end
                        OP_WRITE_AT:
                        begin
                            mem_we = 1'b1;
                            mem_wa = q_cmd.addr;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            cursor_next = '0;
                            col_next    = '0;
                            row_next    = '0;
                            cnt_next    = '0;
                            state_next  = ST_FILL;
                        end
                        OP_SET_CURSOR:
                        begin
                            // row/column recovered by repeated subtraction
                            cursor_next = q_cmd.addr;
                            cnt_next    = q_cmd.addr;
                            row_next    = '0;
                            state_next  = ST_DIVIDE;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_scroll)
                    begin
                        cursor_next  = ADDR_W'(CELLS - COLUMNS);
                        row_next     = ROW_W'(ROWS - 1);
                        col_next     = '0;
                        cnt_next     = '0;
                        res_scr_next = 1'b1;
                        state_next   = ST_COPY;
                    end
                    else if (q_cmd.op == OP_PUT_CHAR || q_cmd.op == OP_NEWLINE ||
                             q_cmd.op == OP_RETURN || q_cmd.op == OP_WRITE_AT ||
                             q_cmd.op == OP_NOP)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{cell_char: '0, cell_attr: '0,
                                           cursor_pos: cursor_next, scrolled: 1'b0};
                    end
                end
            end
            ST_READ:
            begin
                res_char_next = rd_data_reg[CHAR_W-1:0];
                res_attr_next = rd_data_reg[CELL_W-1:CHAR_W];
                state_next    = ST_RESPOND;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg >= ADDR_W'(COLUMNS))
                begin
                    cnt_next = cnt_reg - ADDR_W'(COLUMNS);
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next   = cnt_reg[COL_W-1:0];
                    state_next = ST_RESPOND;
                end
            end
            ST_COPY:
            begin
                // read one row below; the cell read on the previous pass is written back one row up
                rd_addr = cnt_reg + ADDR_W'(COLUMNS);
                mem_we  = pend_valid_reg;
                mem_wa  = pend_addr_reg;
                mem_wd  = rd_data_reg;
                if (cnt_reg < ADDR_W'(CELLS - COLUMNS))
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = cnt_reg;
                    cnt_next        = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                mem_wa   = cnt_reg;
                mem_wd   = BLANK_CELL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_RESPOND;
                end
            end
            ST_RESPOND:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{cell_char: res_char_reg, cell_attr: res_attr_reg,
                                       cursor_pos: cursor_reg, scrolled: res_scr_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            cursor_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            cnt_reg        <= '0;
            init_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            cnt_reg        <= cnt_next;
            init_reg       <= init_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        res_char_reg  <= res_char_next;
        res_attr_reg  <= res_attr_next;
        res_scr_reg   <= res_scr_next;
        rsp_reg       <= rsp_next;
    end

endmodule

[rtl/core/text_console_writer_core.sv]
// Text console writer, 80x25 cells of character plus attribute, with a cursor.
// One result per request. After reset the cell memory is blanked by a clearing
// pass, during which req_stall is high. A request passes the front end and a
// two-entry command queue, then the engine, which owns the single-port-write
// cell memory: put char, put at, cursor return and unknown requests finish
// from idle, read waits for the memory, set cursor finds the row by repeated
// subtraction, clear screen blanks all cells, and a put char or newline that
// scrolls moves the cells up a row (one cell moved per cycle), then blanks the
// bottom row. The text_color register sits at byte address 0 and must only
// be written idle. Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
module text_console_writer_core import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CHAR_W-1:0] text_color_reg;
    logic [CHAR_W-1:0] text_color_next;
    logic              init_busy;
    logic              q_full;
    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    logic              q_valid;
    cmd_t              q_cmd;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_TEXT_COLOR);
    assign prdata  = reg_sel ? {24'b0, text_color_reg} : 32'b0;

    always_comb
    begin
        text_color_next = text_color_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            text_color_next = pwdata[CHAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tcw_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .text_color (text_color_reg),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tcw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[rtl/core/tcw_checker.sv]
// Port-level checks for text_console_writer_core, bound to the top level.
// Depends on tcw_pkg.
module tcw_checker import tcw_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result transfer dropped while stalled");

    // clearing pass holds off requests straight after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> req_stall)
        else $error("request accepted during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.cursor_pos) < CELLS))
        else $error("cursor outside the grid");

    // a scroll always leaves the cursor at the start of the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> (int'(rsp.cursor_pos) == CELLS - COLUMNS))
        else $error("scroll left cursor off the last row");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

[tb/tcw_screen_checker.sv]
// Checker for the text console writer: mirrors the screen, cursor and colour,
// predicts each response and compares it with what the block returns.
// Depends on tcw_pkg for the request/response structs and grid constants.
module tcw_screen_checker import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  req_t               req,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

    logic [CELL_W-1:0] cells [CELLS];
    int unsigned       cursor_at;
    logic [CHAR_W-1:0] color;
    rsp_t              due_rsps [$];

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $realtime, what);
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            cells[i] = BLANK_CELL;
    endfunction

    // applies one request to the mirrored screen and returns its response
    function automatic rsp_t next_console_rsp(input req_t r);
        rsp_t o;
        o = '0;
        case (r.req_type)
            REQ_PUT_CHAR:
            begin
                if (r.char_code == NL_CODE)
                    cursor_at += COLUMNS - cursor_at % COLUMNS;
                else if (r.char_code == CR_CODE)
                    cursor_at -= cursor_at % COLUMNS;
                else
                begin
                    cells[cursor_at] = {color, r.char_code};
                    cursor_at++;
                end
                if (cursor_at >= CELLS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        cells[i] = cells[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        cells[i] = BLANK_CELL;
                    cursor_at  = CELLS - COLUMNS;
                    o.scrolled = 1'b1;
                end
            end
            REQ_PUT_AT:
            begin
                // control bytes go in as plain characters here
                if (r.column < COLUMNS && r.row < ROWS)
                    cells[r.row * COLUMNS + r.column] = {color, r.char_code};
            end
            REQ_READ:
            begin
                if (r.position < CELLS)
                    {o.cell_attr, o.cell_char} = cells[r.position];
            end
            REQ_CLEAR:
            begin
                blank_screen();
                cursor_at = 0;
            end
            REQ_SET_CURSOR:
            begin
                cursor_at = (r.position < CELLS) ? r.position : CELLS - 1;
            end
            default:
            begin
            end
        endcase
        o.cursor_pos = ADDR_W'(cursor_at);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            blank_screen();
            cursor_at = 0;
            color     = RESET_COLOR;
            due_rsps.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsps.size() == 0)
                    report($sformatf("response with none due: char %h attr %h cursor %0d scr %b",
                                     rsp.cell_char, rsp.cell_attr, rsp.cursor_pos, rsp.scrolled));
                else
                begin
                    want = due_rsps.pop_front();
                    if (rsp.cell_char !== want.cell_char || rsp.cell_attr !== want.cell_attr ||
                        rsp.cursor_pos !== want.cursor_pos || rsp.scrolled !== want.scrolled)
                        report($sformatf({"response mismatch: exp char %h attr %h cursor %0d",
                                          " scr %b, got char %h attr %h cursor %0d scr %b"},
                                         want.cell_char, want.cell_attr, want.cursor_pos,
                                         want.scrolled, rsp.cell_char, rsp.cell_attr,
                                         rsp.cursor_pos, rsp.scrolled));
                end
            end
            if (req_valid && !req_stall)
                due_rsps.push_back(next_console_rsp(req));
            if (psel && penable && pready && paddr == COLOR_ADDR)
            begin
                if (pwrite)
                    color = pwdata[CHAR_W-1:0];
                else if (prdata[CHAR_W-1:0] !== color)
                    report($sformatf("text_color readback: exp %h, got %h",
                                     color, prdata[CHAR_W-1:0]));
            end
            pending <= due_rsps.size();
        end
    end

endmodule

[tb/tb_text_console_writer_core.sv]
// Top of the text console writer testbench: clock, reset, request stimulus,
// register writes and the final verdict. Depends on tcw_pkg, the block
// text_console_writer_core and the checker tcw_screen_checker.
module tb_text_console_writer_core import tcw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] COLOR_ADDR       = {REG_TEXT_COLOR, 2'b00};
    localparam logic [REQ_W-1:0]   REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]   REQ_UNUSED_LAST  = 3'd7;
    localparam int                 PHASE_ITEMS      = 138;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          fail_count;
    int          pending;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned last_mark = 0;

    text_console_writer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tcw_screen_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    initial
    begin
        #100_000_000;
        $display("tb_text_console_writer_core: FAIL");
        $finish;
    end

    function automatic req_t make_req(input logic [REQ_W-1:0] t, input logic [CHAR_W-1:0] c,
                                      input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
                                      input logic [ADDR_W-1:0] p);
        req_t r;
        r.req_type  = t;
        r.char_code = c;
        r.column    = x;
        r.row       = y;
        r.position  = p;
        return r;
    endfunction

    // mostly in-grid requests; reads favour the last written or cursor spot
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned sub;
        r.char_code = CHAR_W'($urandom_range(255));
        r.column    = COL_W'($urandom_range(127));
        r.row       = ROW_W'($urandom_range(31));
        r.position  = ADDR_W'($urandom_range(2047));
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (pick < 55)
        begin
            r.req_type = REQ_PUT_CHAR;
            if (sub < 7)
                r.char_code = NL_CODE;
            else if (sub < 12)
                r.char_code = CR_CODE;
        end
        else if (pick < 70)
        begin
            r.req_type = REQ_PUT_AT;
            if (sub >= 10)
            begin
                r.column = COL_W'($urandom_range(COLUMNS - 1));
                r.row    = ROW_W'($urandom_range(ROWS - 1));
            end
            if (r.column < COLUMNS && r.row < ROWS)
                last_mark = r.row * COLUMNS + r.column;
        end
        else if (pick < 85)
        begin
            r.req_type = REQ_READ;
            if (sub < 50)
                r.position = ADDR_W'(last_mark + $urandom_range(3));
            else if (sub < 90)
                r.position = ADDR_W'($urandom_range(CELLS - 1));
        end
        else if (pick < 95)
        begin
            r.req_type = REQ_SET_CURSOR;
            // near the bottom so that following text scrolls soon
            if (sub < 30)
                r.position = ADDR_W'($urandom_range(CELLS - 1, CELLS - COLUMNS - 20));
            else if (sub < 90)
                r.position = ADDR_W'($urandom_range(CELLS - 1));
            if (r.position < CELLS)
                last_mark = r.position;
        end
        else if (pick < 97)
            r.req_type = REQ_CLEAR;
        else
            r.req_type = REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
        return r;
    endfunction

    task automatic send(input req_t r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic reg_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= COLOR_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CHAR_W-1:0] phase_color;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, control bytes, off-grid, scroll and clear
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_CHAR, 8'h41, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_CHAR, 8'h00, 7'd127, 5'd31, 11'd2047));
        send(make_req(REQ_PUT_CHAR, 8'hff, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_CHAR, CR_CODE, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_CHAR, NL_CODE, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_AT, 8'hff, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_AT, NL_CODE, 7'd79, 5'd24, 11'd0));
        send(make_req(REQ_PUT_AT, 8'h55, 7'd80, 5'd0, 11'd0));
        send(make_req(REQ_PUT_AT, 8'h66, 7'd0, 5'd25, 11'd0));
        send(make_req(REQ_PUT_AT, 8'h77, 7'd127, 5'd31, 11'd2047));
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd1999));
        send(make_req(REQ_READ, 8'hff, 7'd127, 5'd31, 11'd2000));
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd2047));
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_SET_CURSOR, 8'h00, 7'd0, 5'd0, 11'd1999));
        send(make_req(REQ_PUT_CHAR, 8'h78, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd1919));
        send(make_req(REQ_SET_CURSOR, 8'h00, 7'd0, 5'd0, 11'd2047));
        send(make_req(REQ_PUT_CHAR, NL_CODE, 7'd0, 5'd0, 11'd0));
        send(make_req(REQ_PUT_CHAR, CR_CODE, 7'd0, 5'd0, 11'd0));
        for (int u = REQ_UNUSED_FIRST; u <= REQ_UNUSED_LAST; u++)
            send(make_req(REQ_W'(u), CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
                          ADDR_W'($urandom)));
        send(make_req(REQ_CLEAR, 8'hff, 7'd127, 5'd31, 11'd2047));
        send(make_req(REQ_READ, 8'h00, 7'd0, 5'd0, 11'd1919));

        // each phase: drain, change colour while idle, then random transfers
        for (int phase = 0; phase < 4; phase++)
        begin
            req_valid <= 1'b0;
            wait_drained();
            case (phase)
                0: phase_color = 8'hff;
                1: phase_color = 8'h00;
                default: phase_color = CHAR_W'($urandom_range(255));
            endcase
            reg_access(1'b1, {24'($urandom), phase_color});
            reg_access(1'b0, 32'd0);
            idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 19 : 0;
            stall_pct <= (phase == 2) ? 85 : (phase == 3) ? 19 : 0;
            repeat (PHASE_ITEMS)
                send(random_request());
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (4100) @(posedge clk);
        if (fail_count == 0)
            $display("tb_text_console_writer_core: PASS");
        else
            $display("tb_text_console_writer_core: FAIL");
        $finish;
    end

endmodule
